>>> design/hemisphere_direction_sampler_macros.svh
// Assertion macros for the hemisphere direction sampler.
// Included by the files that assert; depends on nothing.
`ifndef HEMISPHERE_DIRECTION_SAMPLER_MACROS_SVH
`define HEMISPHERE_DIRECTION_SAMPLER_MACROS_SVH
`ifndef ASSERT_OFF
`define HDS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("hds: check failed");
`define HDS_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("hds: reset check failed");
`else
`define HDS_ASSERT(lbl, clk, rstn, prop)
`define HDS_ASSERT_RST(lbl, clk, prop)
`endif
`endif

>>> design/hds_pkg.sv
// Shared types, constants and helper functions of the hemisphere direction sampler.
// Used by hds_isqrt, hds_cordic and the top level; depends on nothing.
`default_nettype none

package hds_pkg;

  localparam int unsigned FRACTION_BITS_DEF   = 16;
  localparam int unsigned ROTATION_STAGES_DEF = 16;

  localparam int unsigned U_W     = 16;
  localparam int unsigned Z_W     = 15;
  localparam int unsigned D_W     = 16;
  localparam int unsigned OUT_W   = 16;
  localparam int unsigned SQ_OP_W = 34;
  localparam int unsigned SQ_RT_W = SQ_OP_W / 2;
  localparam int unsigned RESID_W = 14;
  localparam int unsigned PI_W    = 33;
  localparam int unsigned THETA_W = 31;
  localparam int unsigned ANG_W   = 33;

  localparam logic [PI_W-1:0]  TWO_PI_Q30      = 33'd6746518852;
  localparam logic [63:0]      INV_GAIN_Q32    = 64'd2608131496;
  localparam logic [D_W-1:0]   UNIFORM_DENSITY = 16'd10430;
  localparam logic [19:0]      TWO_OVER_PI_Q20 = 20'd667544;
  localparam logic [D_W-1:0]   DENSITY_MAX     = 16'd20861;
  localparam logic [SQ_RT_W-1:0] RADIUS_MAX    = 17'd65536;
  localparam logic [Z_W-1:0]   Z_MAX           = 15'd32767;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef struct packed {
    logic               mode;
    logic [U_W-1:0]     u1;
    quad_e              quad;
    logic [THETA_W-1:0] theta;
  } sq_side_t;

  typedef struct packed {
    logic                 mode;
    quad_e                quad;
    logic [Z_W-1:0]       z15;
    logic [D_W-1:0]       density;
    logic [SQ_RT_W-1:0]   radius;
  } rot_side_t;

  localparam logic [31:0] BASE_ANG [11] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149, 32'd1048576
  };

  function automatic logic [ANG_W-1:0] cordic_angle(input int unsigned i);
    logic [ANG_W-1:0] a;
    if (i < 11) begin
      a = ANG_W'(BASE_ANG[i]);
    end else if (i <= 30) begin
      a = ANG_W'(1) << (30 - i);
    end else begin
      a = '0;
    end
    return a;
  endfunction

  function automatic logic [63:0] cordic_x0(input int unsigned f);
    logic [63:0] v;
    if (f >= 32) begin
      v = INV_GAIN_Q32;
    end else begin
      v = (INV_GAIN_Q32 + (64'd1 << (31 - f))) >> (32 - f);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

>>> design/hemisphere_direction_sampler.sv
// Top level of the hemisphere direction sampler: input prep, square roots, rotator, scaling.
// Depends on hds_pkg, hds_isqrt, hds_cordic and the assertion macro header.
//
// Usage:
//   Drive mode_i, first_uniform_i and second_uniform_i with start_i high; the beat is
//   taken at that edge. busy_o stays low, so a new pair is taken in every cycle.
//   Each beat yields one result on dir_x_o, dir_y_o, dir_z_o and density_o, shown for
//   exactly one cycle with done_o high, in input order.
//   Throughput: one beat per cycle.
//   The depth is set by two input stages, the 17-stage square root pipeline (one root
//   bit per stage), two z and density stages, the CORDIC pipeline (one rotation per
//   stage) and three output stages (quadrant fold, multiply, round and saturate).
//   Reset clears all valid bits at once; no result appears until a beat has passed
//   through the whole pipeline. The receiver cannot stall, so no result is held.
`default_nettype none
`include "hemisphere_direction_sampler_macros.svh"

module hemisphere_direction_sampler import hds_pkg::*; #(
  parameter int unsigned FRACTION_BITS   = FRACTION_BITS_DEF,
  parameter int unsigned ROTATION_STAGES = ROTATION_STAGES_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic                    mode_i,
  input  wire logic [U_W-1:0]          first_uniform_i,
  input  wire logic [U_W-1:0]          second_uniform_i,
  output logic                         done_o,
  output logic signed [OUT_W-1:0]      dir_x_o,
  output logic signed [OUT_W-1:0]      dir_y_o,
  output logic [Z_W-1:0]               dir_z_o,
  output logic [D_W-1:0]               density_o
);

  localparam int unsigned TRIG_W = FRACTION_BITS + 2;
  localparam int unsigned CX_W   = TRIG_W + 1;
  localparam int unsigned PR_W   = CX_W + SQ_RT_W + 1;

  // stage 0: register beat, form products
  logic                       v0_q;
  logic                       mode0_q;
  logic [U_W-1:0]             u1_0_q;
  quad_e                      quad0_q;
  logic [RESID_W+PI_W-1:0]    tprod0_q;
  logic [2*U_W-1:0]           usq0_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    mode0_q  <= mode_i;
    u1_0_q   <= first_uniform_i;
    quad0_q  <= quad_e'(second_uniform_i[U_W-1 -: 2]);
    tprod0_q <= (RESID_W+PI_W)'(second_uniform_i[RESID_W-1:0]) * (RESID_W+PI_W)'(TWO_PI_Q30);
    usq0_q   <= first_uniform_i * first_uniform_i;
  end

  // stage 1: square root operands, rounded angle
  logic                       v1_q;
  logic [1:0][SQ_OP_W-1:0]    op1_d, op1_q;
  sq_side_t                   sq_side1_d, sq_side1_q;
  logic [RESID_W+PI_W-1:0]    trnd1;

  always_comb begin
    trnd1    = tprod0_q + (RESID_W+PI_W)'(1 << 15);
    op1_d[0] = {2'b00, u1_0_q, 16'h0000};
    if (mode0_q) begin
      op1_d[1] = {1'b0, 17'd65536 - {1'b0, u1_0_q}, 16'h0000};
    end else begin
      op1_d[1] = (SQ_OP_W'(1) << 32) - SQ_OP_W'(usq0_q);
    end
    sq_side1_d.mode  = mode0_q;
    sq_side1_d.u1    = u1_0_q;
    sq_side1_d.quad  = quad0_q;
    sq_side1_d.theta = trnd1[16 +: THETA_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q      <= op1_d;
    sq_side1_q <= sq_side1_d;
  end

  logic                     sq_v;
  logic [1:0][SQ_RT_W-1:0]  sq_root;
  sq_side_t                 sq_side;

  hds_isqrt #(
    .OP_W   (SQ_OP_W),
    .SIDE_W ($bits(sq_side_t))
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q),
    .op_i    (op1_q),
    .side_i  (sq_side1_q),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // stage P1: z component
  logic                   vp1_q;
  logic [SQ_RT_W-1:0]     zsum;
  logic [Z_W-1:0]         z15_d, z15_q;
  logic [SQ_RT_W-1:0]     radius_p1_q;
  sq_side_t               side_p1_q;

  always_comb begin
    if (sq_side.mode) begin
      zsum = (sq_root[0] + SQ_RT_W'(1)) >> 1;
    end else begin
      zsum = (SQ_RT_W'(sq_side.u1) + SQ_RT_W'(1)) >> 1;
    end
    z15_d = (zsum > SQ_RT_W'(Z_MAX)) ? Z_MAX : zsum[Z_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp1_q <= 1'b0;
    end else begin
      vp1_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    z15_q       <= z15_d;
    radius_p1_q <= sq_root[1];
    side_p1_q   <= sq_side;
  end

  // stage P2: density
  logic                   vp2_q;
  logic [Z_W+20-1:0]      dprod;
  rot_side_t              rot_side_d, rot_side_q;
  logic [THETA_W-1:0]     theta_p2_q;

  always_comb begin
    dprod              = (Z_W+20)'(z15_q) * (Z_W+20)'(TWO_OVER_PI_Q20) + (Z_W+20)'(1 << 19);
    rot_side_d.mode    = side_p1_q.mode;
    rot_side_d.quad    = side_p1_q.quad;
    rot_side_d.z15     = z15_q;
    rot_side_d.density = side_p1_q.mode ? dprod[20 +: D_W] : UNIFORM_DENSITY;
    rot_side_d.radius  = radius_p1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp2_q <= 1'b0;
    end else begin
      vp2_q <= vp1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rot_side_q <= rot_side_d;
    theta_p2_q <= side_p1_q.theta;
  end

  logic                       rot_v;
  logic signed [TRIG_W-1:0]   rot_cos;
  logic signed [TRIG_W-1:0]   rot_sin;
  rot_side_t                  rot_side;

  hds_cordic #(
    .FRAC_W (FRACTION_BITS),
    .STAGES (ROTATION_STAGES),
    .SIDE_W ($bits(rot_side_t))
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vp2_q),
    .angle_i (theta_p2_q),
    .side_i  (rot_side_q),
    .valid_o (rot_v),
    .cos_o   (rot_cos),
    .sin_o   (rot_sin),
    .side_o  (rot_side)
  );

  // stage M1: quadrant fold
  logic                     vm1_q;
  logic signed [CX_W-1:0]   c_ext, s_ext;
  logic signed [CX_W-1:0]   cx_d, sy_d, cx_q, sy_q;
  rot_side_t                side_m1_q;

  always_comb begin
    c_ext = CX_W'(rot_cos);
    s_ext = CX_W'(rot_sin);
    case (rot_side.quad)
      QUAD_0: begin
        cx_d = c_ext;
        sy_d = s_ext;
      end
      QUAD_1: begin
        cx_d = -s_ext;
        sy_d = c_ext;
      end
      QUAD_2: begin
        cx_d = -c_ext;
        sy_d = -s_ext;
      end
      default: begin
        cx_d = s_ext;
        sy_d = -c_ext;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm1_q <= 1'b0;
    end else begin
      vm1_q <= rot_v;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q      <= cx_d;
    sy_q      <= sy_d;
    side_m1_q <= rot_side;
  end

  // stage M2: scale by radius
  logic                     vm2_q;
  logic signed [PR_W-1:0]   px_q, py_q;
  logic signed [PR_W-1:0]   r_ext;
  rot_side_t                side_m2_q;

  assign r_ext = $signed(PR_W'(side_m1_q.radius));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm2_q <= 1'b0;
    end else begin
      vm2_q <= vm1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q      <= PR_W'(cx_q) * r_ext;
    py_q      <= PR_W'(sy_q) * r_ext;
    side_m2_q <= side_m1_q;
  end

  // stage M3: round, saturate, output register
  logic signed [PR_W-1:0]   vx, vy;
  logic signed [OUT_W-1:0]  sx_d, sy_sat_d;
  logic                     done_q;
  logic                     mode_out_q;
  logic signed [OUT_W-1:0]  dir_x_q, dir_y_q;
  logic [Z_W-1:0]           dir_z_q;
  logic [D_W-1:0]           density_q;

  localparam logic signed [PR_W-1:0] POS_LIM = PR_W'(32767);
  localparam logic signed [PR_W-1:0] NEG_LIM = -PR_W'(32768);
  localparam logic signed [PR_W-1:0] HALF    = PR_W'(1) << FRACTION_BITS;

  always_comb begin
    vx = (px_q + HALF) >>> (FRACTION_BITS + 1);
    vy = (py_q + HALF) >>> (FRACTION_BITS + 1);
    if (vx > POS_LIM) begin
      sx_d = 16'sh7FFF;
    end else if (vx < NEG_LIM) begin
      sx_d = 16'sh8000;
    end else begin
      sx_d = vx[OUT_W-1:0];
    end
    if (vy > POS_LIM) begin
      sy_sat_d = 16'sh7FFF;
    end else if (vy < NEG_LIM) begin
      sy_sat_d = 16'sh8000;
    end else begin
      sy_sat_d = vy[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vm2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dir_x_q    <= sx_d;
    dir_y_q    <= sy_sat_d;
    dir_z_q    <= side_m2_q.z15;
    density_q  <= side_m2_q.density;
    mode_out_q <= side_m2_q.mode;
  end

  assign done_o    = done_q;
  assign dir_x_o   = dir_x_q;
  assign dir_y_o   = dir_y_q;
  assign dir_z_o   = dir_z_q;
  assign density_o = density_q;

  `HDS_ASSERT(a_uniform_density, clk_i, rst_ni, done_o && !mode_out_q |-> density_o == UNIFORM_DENSITY)
  `HDS_ASSERT(a_cosine_density, clk_i, rst_ni, done_o && mode_out_q |-> density_o <= DENSITY_MAX)
  `HDS_ASSERT(a_radius_range, clk_i, rst_ni, vp2_q |-> rot_side_q.radius <= RADIUS_MAX)
  `HDS_ASSERT_RST(a_reset_quiet, clk_i, !rst_ni |=> !done_o)

endmodule

`default_nettype wire

>>> design/hds_isqrt.sv
// Two-lane pipelined integer square root, one root bit per stage.
// Depends on hds_pkg.
`default_nettype none

module hds_isqrt import hds_pkg::*; #(
  parameter int unsigned OP_W   = SQ_OP_W,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire logic [1:0][OP_W-1:0]          op_i,
  input  wire logic [SIDE_W-1:0]             side_i,
  output logic                               valid_o,
  output logic [1:0][OP_W/2-1:0]             root_o,
  output logic [SIDE_W-1:0]                  side_o
);

  localparam int unsigned RT_W  = OP_W / 2;
  localparam int unsigned REM_W = RT_W + 3;

  logic                          vld_q  [RT_W+1];
  logic [1:0][OP_W-1:0]          op_q   [RT_W+1];
  logic [1:0][REM_W-1:0]         rem_q  [RT_W+1];
  logic [1:0][RT_W-1:0]          root_q [RT_W+1];
  logic [SIDE_W-1:0]             side_q [RT_W+1];

  assign vld_q[0]  = valid_i;
  assign op_q[0]   = op_i;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign side_q[0] = side_i;

  for (genvar s = 0; s < RT_W; s++) begin : g_stage
    logic [1:0][OP_W-1:0]  op_d;
    logic [1:0][REM_W-1:0] rem_d;
    logic [1:0][RT_W-1:0]  root_d;

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      logic             ge;

      always_comb begin
        rem_sh    = {rem_q[s][l][REM_W-3:0], op_q[s][l][OP_W-1 -: 2]};
        trial     = REM_W'({root_q[s][l][RT_W-2:0], 2'b01});
        ge        = rem_sh >= trial;
        rem_d[l]  = ge ? rem_sh - trial : rem_sh;
        root_d[l] = {root_q[s][l][RT_W-2:0], ge};
        op_d[l]   = op_q[s][l] << 2;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      op_q[s+1]   <= op_d;
      rem_q[s+1]  <= rem_d;
      root_q[s+1] <= root_d;
      side_q[s+1] <= side_q[s];
    end
  end

  assign valid_o = vld_q[RT_W];
  assign root_o  = root_q[RT_W];
  assign side_o  = side_q[RT_W];

endmodule

`default_nettype wire

>>> design/hds_cordic.sv
// Pipelined CORDIC rotator giving cos and sin of an angle in [0, pi/2).
// Depends on hds_pkg for the stage angles and the start value.
`default_nettype none

module hds_cordic import hds_pkg::*; #(
  parameter int unsigned FRAC_W = FRACTION_BITS_DEF,
  parameter int unsigned STAGES = ROTATION_STAGES_DEF,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire logic [THETA_W-1:0]          angle_i,
  input  wire logic [SIDE_W-1:0]           side_i,
  output logic                             valid_o,
  output logic signed [FRAC_W+1:0]         cos_o,
  output logic signed [FRAC_W+1:0]         sin_o,
  output logic [SIDE_W-1:0]                side_o
);

  localparam int unsigned TRIG_W = FRAC_W + 2;
  localparam logic signed [TRIG_W-1:0] X0 = TRIG_W'(cordic_x0(FRAC_W));

  logic                       vld_q  [STAGES+1];
  logic signed [TRIG_W-1:0]   x_q    [STAGES+1];
  logic signed [TRIG_W-1:0]   y_q    [STAGES+1];
  logic signed [ANG_W-1:0]    z_q    [STAGES+1];
  logic [SIDE_W-1:0]          side_q [STAGES+1];

  assign vld_q[0]  = valid_i;
  assign x_q[0]    = X0;
  assign y_q[0]    = '0;
  assign z_q[0]    = ANG_W'(angle_i);
  assign side_q[0] = side_i;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam logic signed [ANG_W-1:0] ANG = cordic_angle(s);
    logic signed [TRIG_W-1:0] dx;
    logic signed [TRIG_W-1:0] dy;
    logic signed [TRIG_W-1:0] x_d;
    logic signed [TRIG_W-1:0] y_d;
    logic signed [ANG_W-1:0]  z_d;

    always_comb begin
      dx = y_q[s] >>> s;
      dy = x_q[s] >>> s;
      if (!z_q[s][ANG_W-1]) begin
        x_d = x_q[s] - dx;
        y_d = y_q[s] + dy;
        z_d = z_q[s] - ANG;
      end else begin
        x_d = x_q[s] + dx;
        y_d = y_q[s] - dy;
        z_d = z_q[s] + ANG;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      x_q[s+1]    <= x_d;
      y_q[s+1]    <= y_d;
      z_q[s+1]    <= z_d;
      side_q[s+1] <= side_q[s];
    end
  end

  assign valid_o = vld_q[STAGES];
  assign cos_o   = x_q[STAGES];
  assign sin_o   = y_q[STAGES];
  assign side_o  = side_q[STAGES];

endmodule

`default_nettype wire

>>> bench/hemisphere_direction_sampler_tb.sv
// Testbench of the hemisphere direction sampler: directed table, then random bursts.
// Predicts each direction and density with its own square root and rotator model.
// Depends on hds_pkg and the hemisphere_direction_sampler RTL.
`default_nettype none

module hemisphere_direction_sampler_tb;
  import hds_pkg::*;

  localparam int unsigned FRAC  = 16;
  localparam int unsigned STAGE = 16;
  localparam int unsigned LAT   = 24 + STAGE;
  localparam longint CYCLE_LIMIT = 200000;

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic [Z_W-1:0]          z;
    logic [D_W-1:0]          dens;
  } dir_t;

  typedef struct {
    logic           mode;
    logic [U_W-1:0] u1;
    logic [U_W-1:0] u2;
    bit             known;
    logic [Z_W-1:0] z;
    logic [D_W-1:0] dens;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic mode_i = 1'b0;
  logic [U_W-1:0] first_uniform_i = '0;
  logic [U_W-1:0] second_uniform_i = '0;
  logic busy_o, done_o;
  logic signed [OUT_W-1:0] dir_x_o, dir_y_o;
  logic [Z_W-1:0] dir_z_o;
  logic [D_W-1:0] density_o;

  dir_t pending_dirs[$];
  int   errors = 0;
  longint cycles = 0;

  hemisphere_direction_sampler u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .mode_i, .first_uniform_i, .second_uniform_i,
    .done_o, .dir_x_o, .dir_y_o, .dir_z_o, .density_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] to_q15(longint t, longint r);
    longint v;
    v = floor_shift(t * r + (64'sd1 << FRAC), FRAC + 1);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return OUT_W'(v);
  endfunction

  function automatic dir_t sample_direction(logic mode, logic [U_W-1:0] u1,
                                            logic [U_W-1:0] u2);
    dir_t d;
    longint unsigned rad, zz, th;
    longint cx, sy, xc, ys, za;
    quad_e q;
    if (!mode) begin
      zz = (longint'(u1) + 1) >> 1;
      rad = root_floor((64'd1 << 32) - longint'(u1) * u1);
    end else begin
      zz = (root_floor(longint'(u1) << 16) + 1) >> 1;
      rad = root_floor((65536 - longint'(u1)) << 16);
    end
    if (zz > 32767) zz = 32767;
    d.z = Z_W'(zz);
    d.dens = mode ? D_W'((zz * 667544 + (64'd1 << 19)) >> 20) : UNIFORM_DENSITY;
    th = (longint'(u2[13:0]) * 64'd6746518852 + (64'd1 << 15)) >> 16;
    xc = longint'((64'd2608131496 + (64'd1 << (31 - FRAC))) >> (32 - FRAC));
    ys = 0;
    za = longint'(th);
    for (int i = 0; i < STAGE; i++) begin
      longint dx, dy, a;
      dx = floor_shift(ys, i);
      dy = floor_shift(xc, i);
      a = longint'(cordic_angle(i));
      if (za >= 0) begin
        xc -= dx; ys += dy; za -= a;
      end else begin
        xc += dx; ys -= dy; za += a;
      end
    end
    q = quad_e'(u2[15:14]);
    case (q)
      QUAD_0: begin cx = xc;  sy = ys;  end
      QUAD_1: begin cx = -ys; sy = xc;  end
      QUAD_2: begin cx = -xc; sy = -ys; end
      default: begin cx = ys; sy = -xc; end
    endcase
    d.x = to_q15(cx, longint'(rad));
    d.y = to_q15(sy, longint'(rad));
    return d;
  endfunction

  task automatic send_beat(logic mode, logic [U_W-1:0] u1, logic [U_W-1:0] u2,
                           bit known, logic [Z_W-1:0] z, logic [D_W-1:0] dens);
    dir_t d;
    d = sample_direction(mode, u1, u2);
    if (known && (d.z !== z || d.dens !== dens)) begin
      $error("table row: z exp %0d got %0d, density exp %0d got %0d", z, d.z, dens, d.dens);
      errors++;
    end
    start_i <= 1'b1;
    mode_i <= mode;
    first_uniform_i <= u1;
    second_uniform_i <= u2;
    do @(posedge clk_i); while (busy_o);
    pending_dirs = {pending_dirs, d};
  endtask

  task automatic hold_off(int n);
    start_i <= 1'b0;
    mode_i <= 1'($urandom);
    first_uniform_i <= U_W'($urandom);
    second_uniform_i <= U_W'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("hemisphere_direction_sampler_tb: FAIL");
      $finish;
    end else if (rst_ni && done_o) begin
      if (pending_dirs.size() == 0) begin
        $error("result with no beat pending");
        errors++;
      end else begin
        dir_t e;
        e = pending_dirs.pop_front();
        if (dir_x_o !== e.x) begin
          $error("dir_x exp %0d got %0d", e.x, dir_x_o); errors++;
        end
        if (dir_y_o !== e.y) begin
          $error("dir_y exp %0d got %0d", e.y, dir_y_o); errors++;
        end
        if (dir_z_o !== e.z) begin
          $error("dir_z exp %0d got %0d", e.z, dir_z_o); errors++;
        end
        if (density_o !== e.dens) begin
          $error("density exp %0d got %0d", e.dens, density_o); errors++;
        end
      end
    end
  end

  row_t directed[] = '{
    '{1'b0, 16'h0000, 16'h0000, 1'b1, 15'd0,     16'd10430},
    '{1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 15'd32767, 16'd10430},
    '{1'b1, 16'h0000, 16'h0000, 1'b1, 15'd0,     16'd0},
    '{1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 15'd32767, 16'd20860},
    '{1'b0, 16'h0001, 16'h4000, 1'b0, 15'd0, 16'd0},
    '{1'b0, 16'h8000, 16'h8000, 1'b0, 15'd0, 16'd0},
    '{1'b0, 16'hFFFE, 16'hC000, 1'b0, 15'd0, 16'd0},
    '{1'b1, 16'h0001, 16'h3FFF, 1'b0, 15'd0, 16'd0},
    '{1'b1, 16'h4000, 16'h7FFF, 1'b0, 15'd0, 16'd0},
    '{1'b1, 16'h8000, 16'hBFFF, 1'b0, 15'd0, 16'd0},
    '{1'b1, 16'hC000, 16'h2000, 1'b0, 15'd0, 16'd0},
    '{1'b0, 16'h5555, 16'hAAAA, 1'b0, 15'd0, 16'd0},
    '{1'b1, 16'hAAAA, 16'h5555, 1'b0, 15'd0, 16'd0},
    '{1'b0, 16'h0000, 16'h0001, 1'b0, 15'd0, 16'd0},
    '{1'b1, 16'hFFFE, 16'hFFFE, 1'b0, 15'd0, 16'd0}
  };

  initial begin
    int drain;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i])
      send_beat(directed[i].mode, directed[i].u1, directed[i].u2, directed[i].known,
                directed[i].z, directed[i].dens);
    hold_off(3);
    for (int n = 0; n < 800; ) begin
      int burst;
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++, n++)
        send_beat(1'($urandom), U_W'($urandom), U_W'($urandom), 1'b0, '0, '0);
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 12));
    end
    hold_off(0);
    drain = 0;
    while (pending_dirs.size() != 0 && drain < 10 * LAT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (LAT) @(posedge clk_i);
    if (errors == 0 && pending_dirs.size() == 0) begin
      $display("hemisphere_direction_sampler_tb: PASS");
    end else begin
      $display("hemisphere_direction_sampler_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
